@@ hdl/joint_hierarchy_skinning_matrices_macros.svh @@
// Assertion macros shared by the skinning matrix palette RTL.
`ifndef JOINT_HIERARCHY_SKINNING_MATRICES_MACROS_SVH
`define JOINT_HIERARCHY_SKINNING_MATRICES_MACROS_SVH
`ifndef NO_ASSERTIONS
// cond holds at every clock edge out of reset
`define JHSM_ASSERT_ALW(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// cons holds in the same cycle as ante
`define JHSM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// cons holds in the cycle after ante
`define JHSM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define JHSM_ASSERT_ALW(lbl, cond, msg)
`define JHSM_ASSERT_IMP(lbl, ante, cons, msg)
`define JHSM_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

@@ hdl/jhsm_pkg.sv @@
// Shared types, constants and helpers of the skinning matrix palette.
`timescale 1ns / 1ps
package jhsm_pkg;

  localparam int MAX_JOINTS_DEF = 64;
  localparam int FRAC_BITS_DEF  = 16;
  // wide signed width for exact intermediate sums before saturation
  localparam int SW = 66;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_POSE = 1'b1;

  // one matrix row, element i in slice i
  typedef logic [3:0][31:0] row_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_QUAT,
    ST_SCALE,
    ST_WORLD,
    ST_SKIN,
    ST_EMIT
  } state_t;

  // write enables of the three stores
  typedef struct packed {
    logic bind_we;
    logic world_we;
    logic par_we;
  } mem_we_t;

  // clamp a wide signed value to the 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [SW-1:0] v);
    logic signed [31:0] r;
    if (v[SW-1:31] == '0 || v[SW-1:31] == '1) begin
      r = v[31:0];
    end else if (v[SW-1]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7fff_ffff;
    end
    return r;
  endfunction

endpackage

@@ hdl/jhsm_ifs.sv @@
// Request channel interfaces: pose/load input and skinning row output.
`timescale 1ns / 1ps
interface jhsm_pose_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic [5:0]         joint;
  logic signed [31:0] word0;
  logic signed [31:0] word1;
  logic signed [31:0] word2;
  logic signed [31:0] word3;
  logic signed [31:0] word4;
  logic signed [31:0] word5;
  logic signed [31:0] word6;
  logic signed [31:0] word7;
  logic signed [31:0] word8;
  logic signed [31:0] word9;

  modport source (output valid, mode, joint, word0, word1, word2, word3, word4,
                  word5, word6, word7, word8, word9, input ready);
  modport sink (input valid, mode, joint, word0, word1, word2, word3, word4,
                word5, word6, word7, word8, word9, output ready);
endinterface

interface jhsm_row_if;
  logic               valid;
  logic               ready;
  logic [5:0]         out_joint;
  logic [1:0]         out_row;
  logic signed [31:0] elem0;
  logic signed [31:0] elem1;
  logic signed [31:0] elem2;
  logic signed [31:0] elem3;
  logic               last_row;

  modport source (output valid, out_joint, out_row, elem0, elem1, elem2, elem3,
                  last_row, input ready);
  modport sink (input valid, out_joint, out_row, elem0, elem1, elem2, elem3,
                last_row, output ready);
endinterface

@@ hdl/jhsm_mul4.sv @@
// Four registered Q-format multipliers with floor rounding.
`timescale 1ns / 1ps
module jhsm_mul4 #(
  parameter int FRAC_BITS = jhsm_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  jhsm_pkg::row_t               a,
  input  jhsm_pkg::row_t               b,
  output logic [3:0][63-FRAC_BITS:0]   p
);

  logic signed [63:0] prod [4];

  // full products
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      prod[i] = $signed(a[i]) * $signed(b[i]);
    end
  end

  // drop fraction bits: arithmetic shift is floor
  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      p[i] <= prod[i][63:FRAC_BITS];
    end
  end

endmodule

@@ hdl/jhsm_store.sv @@
// Bind, world and parent stores: one write and one registered read each.
`timescale 1ns / 1ps
module jhsm_store #(
  parameter int MAX_JOINTS = jhsm_pkg::MAX_JOINTS_DEF,
  parameter int AW = 6
) (
  input  logic             clk,
  input  jhsm_pkg::mem_we_t we,
  input  logic [AW+1:0]    bind_waddr,
  input  jhsm_pkg::row_t   bind_wdata,
  input  logic [AW+1:0]    bind_raddr,
  output jhsm_pkg::row_t   bind_rdata,
  input  logic [AW+1:0]    world_waddr,
  input  jhsm_pkg::row_t   world_wdata,
  input  logic [AW+1:0]    world_raddr,
  output jhsm_pkg::row_t   world_rdata,
  input  logic [AW-1:0]    par_waddr,
  input  logic [5:0]       par_wdata,
  input  logic [AW-1:0]    par_raddr,
  output logic [5:0]       par_rdata
);

  jhsm_pkg::row_t bind_mem  [MAX_JOINTS*4];
  jhsm_pkg::row_t world_mem [MAX_JOINTS*4];
  logic [5:0]     par_mem   [MAX_JOINTS];

  // inverse-bind rows
  always_ff @(posedge clk) begin
    if (we.bind_we) begin
      bind_mem[bind_waddr] <= bind_wdata;
    end
    bind_rdata <= bind_mem[bind_raddr];
  end

  // world rows
  always_ff @(posedge clk) begin
    if (we.world_we) begin
      world_mem[world_waddr] <= world_wdata;
    end
    world_rdata <= world_mem[world_raddr];
  end

  // parent indexes
  always_ff @(posedge clk) begin
    if (we.par_we) begin
      par_mem[par_waddr] <= par_wdata;
    end
    par_rdata <= par_mem[par_raddr];
  end

endmodule

@@ hdl/joint_hierarchy_skinning_matrices.sv @@
// Top level: sequencer and datapath of the skinning matrix palette.
//
//   channel   dir   handshake      carries
//   pose      in    valid/ready    mode, joint, word0..word9
//   palette   out   valid/ready    out_joint, out_row, elem0..elem3, last_row
//
// A load request in range is written to the stores when accepted. A pose
// request runs its accept, quaternion, scale, world and skin phases on the four
// shared multipliers, then four row results that wait out output stalls. Matrix
// products run at one element (four products) per cycle. rst is synchronous and
// clears only the sequencer; the stores hold garbage until written. Input is
// taken only while no pose is in progress and never during reset.
`timescale 1ns / 1ps
`include "joint_hierarchy_skinning_matrices_macros.svh"
module joint_hierarchy_skinning_matrices #(
  parameter int MAX_JOINTS = jhsm_pkg::MAX_JOINTS_DEF,
  parameter int FRAC_BITS  = jhsm_pkg::FRAC_BITS_DEF
) (
  input logic         clk,
  input logic         rst,
  jhsm_pose_if.sink   pose,
  jhsm_row_if.source  palette
);

  localparam int AW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
  localparam int PW = 64 - FRAC_BITS;
  localparam int SW = jhsm_pkg::SW;
  localparam logic signed [31:0] ONE  = 32'(1 << FRAC_BITS);
  localparam logic [8:0]         JLIM = 9'(MAX_JOINTS);

  jhsm_pkg::state_t state, state_next;
  logic [4:0] cnt, cnt_next;
  logic       pend_w, pend_s;
  logic [3:0] pidx;
  logic       iss_w, iss_s;

  // request decode
  logic acc, jok, row_ok, par_ok, start, load;
  logic [5:0] par_wr;

  assign acc    = pose.valid && pose.ready;
  assign jok    = {3'b000, pose.joint} < JLIM;
  assign row_ok = pose.word0[31:2] == '0;
  assign par_ok = !pose.word5[31] && pose.word5[30:6] == '0 && pose.word5[5:0] < pose.joint;
  assign par_wr = par_ok ? pose.word5[5:0] : pose.joint;
  assign start  = acc && pose.mode == jhsm_pkg::MODE_POSE && jok;
  assign load   = acc && pose.mode == jhsm_pkg::MODE_LOAD && jok && row_ok;

  // pose registers
  logic [5:0]         joint_q, par_q;
  logic               has_par;
  logic signed [31:0] qx, qy, qz, qw;
  logic signed [31:0] scl [3];
  logic signed [PW-1:0] qp [9];
  logic signed [31:0] rot [9];
  logic signed [31:0] rot_n [9];
  jhsm_pkg::row_t     loc [3];
  jhsm_pkg::row_t     bind_m [4];
  jhsm_pkg::row_t     world_m [4];
  jhsm_pkg::row_t     skin_m [4];

  assign has_par = par_q < joint_q;

  // store and multiplier hookup
  jhsm_pkg::mem_we_t  we;
  logic [AW+1:0]      bind_raddr, world_raddr, world_waddr;
  jhsm_pkg::row_t     bind_rdata, world_rdata, world_wdata, bind_wdata;
  logic [5:0]         par_rdata;
  jhsm_pkg::row_t     ma, mb;
  logic [3:0][PW-1:0] pr;
  logic [3:0]         wrow_ahd;
  logic [1:0]         wrow;

  assign bind_wdata = {pose.word4, pose.word3, pose.word2, pose.word1};

  jhsm_store #(.MAX_JOINTS(MAX_JOINTS), .AW(AW)) u_store (
    .clk         (clk),
    .we          (we),
    .bind_waddr  ({AW'(pose.joint), pose.word0[1:0]}),
    .bind_wdata  (bind_wdata),
    .bind_raddr  (bind_raddr),
    .bind_rdata  (bind_rdata),
    .world_waddr (world_waddr),
    .world_wdata (world_wdata),
    .world_raddr (world_raddr),
    .world_rdata (world_rdata),
    .par_waddr   (AW'(pose.joint)),
    .par_wdata   (par_wr),
    .par_raddr   (AW'(pose.joint)),
    .par_rdata   (par_rdata)
  );

  jhsm_mul4 #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk (clk),
    .a   (ma),
    .b   (mb),
    .p   (pr)
  );

  // sum of four floored products, saturated once
  logic signed [SW-1:0] sum_w;
  logic signed [31:0]   sum_sat;
  assign sum_w = SW'($signed(pr[0])) + SW'($signed(pr[1]))
               + SW'($signed(pr[2])) + SW'($signed(pr[3]));
  assign sum_sat = jhsm_pkg::sat32(sum_w);

  // rotation matrix from quaternion products
  logic signed [SW-1:0] e_xx, e_yy, e_zz, e_xy, e_xz, e_yz, e_wx, e_wy, e_wz, one_w;
  always_comb begin
    e_xx = SW'(qp[0]);
    e_yy = SW'(qp[1]);
    e_zz = SW'(qp[2]);
    e_xy = SW'(qp[3]);
    e_xz = SW'(qp[4]);
    e_yz = SW'(qp[5]);
    e_wx = SW'(qp[6]);
    e_wy = SW'(qp[7]);
    e_wz = SW'(qp[8]);
    one_w = SW'(ONE);
    rot_n[0] = jhsm_pkg::sat32(one_w - ((e_yy + e_zz) <<< 1));
    rot_n[1] = jhsm_pkg::sat32((e_xy - e_wz) <<< 1);
    rot_n[2] = jhsm_pkg::sat32((e_xz + e_wy) <<< 1);
    rot_n[3] = jhsm_pkg::sat32((e_xy + e_wz) <<< 1);
    rot_n[4] = jhsm_pkg::sat32(one_w - ((e_xx + e_zz) <<< 1));
    rot_n[5] = jhsm_pkg::sat32((e_yz - e_wx) <<< 1);
    rot_n[6] = jhsm_pkg::sat32((e_xz - e_wy) <<< 1);
    rot_n[7] = jhsm_pkg::sat32((e_yz + e_wx) <<< 1);
    rot_n[8] = jhsm_pkg::sat32(one_w - ((e_xx + e_yy) <<< 1));
  end

  // next state
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    case (state)
      jhsm_pkg::ST_IDLE: begin
        if (start) begin
          state_next = jhsm_pkg::ST_QUAT;
          cnt_next   = '0;
        end
      end
      jhsm_pkg::ST_QUAT: begin
        if (cnt == 5'd4) begin
          state_next = jhsm_pkg::ST_SCALE;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + 5'd1;
        end
      end
      jhsm_pkg::ST_SCALE: begin
        if (cnt == 5'd3) begin
          state_next = jhsm_pkg::ST_WORLD;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + 5'd1;
        end
      end
      jhsm_pkg::ST_WORLD: begin
        if (cnt == 5'd16) begin
          state_next = jhsm_pkg::ST_SKIN;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + 5'd1;
        end
      end
      jhsm_pkg::ST_SKIN: begin
        if (cnt == 5'd16) begin
          state_next = jhsm_pkg::ST_EMIT;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + 5'd1;
        end
      end
      jhsm_pkg::ST_EMIT: begin
        if (palette.ready) begin
          if (cnt[1:0] == 2'd3) begin
            state_next = jhsm_pkg::ST_IDLE;
            cnt_next   = '0;
          end else begin
            cnt_next = cnt + 5'd1;
          end
        end
      end
      default: begin
        state_next = jhsm_pkg::ST_IDLE;
        cnt_next   = '0;
      end
    endcase
  end

  // world read row is taken from the next count, so the registered read meets the multiplier
  assign wrow_ahd = cnt[3:0] + 4'd1;
  assign wrow     = (state == jhsm_pkg::ST_WORLD) ? wrow_ahd[3:2] : 2'd0;

  // outputs: handshake, store ports, multiplier operands
  always_comb begin
    pose.ready   = !rst && state == jhsm_pkg::ST_IDLE;
    palette.valid = state == jhsm_pkg::ST_EMIT;
    palette.out_joint = joint_q;
    palette.out_row   = cnt[1:0];
    palette.elem0     = skin_m[cnt[1:0]][0];
    palette.elem1     = skin_m[cnt[1:0]][1];
    palette.elem2     = skin_m[cnt[1:0]][2];
    palette.elem3     = skin_m[cnt[1:0]][3];
    palette.last_row  = cnt[1:0] == 2'd3;

    we.bind_we  = load;
    we.par_we   = load;
    we.world_we = pend_w && pidx[1:0] == 2'd3;
    bind_raddr  = {AW'(joint_q), cnt[1:0]};
    world_raddr = {AW'(par_q), wrow};
    world_waddr = {AW'(joint_q), pidx[3:2]};
    world_wdata = world_m[pidx[3:2]];
    world_wdata[3] = sum_sat;

    ma    = '0;
    mb    = '0;
    iss_w = 1'b0;
    iss_s = 1'b0;
    case (state)
      jhsm_pkg::ST_QUAT: begin
        case (cnt)
          5'd0: begin
            ma[0] = qx; mb[0] = qx;
            ma[1] = qy; mb[1] = qy;
            ma[2] = qz; mb[2] = qz;
            ma[3] = qx; mb[3] = qy;
          end
          5'd1: begin
            ma[0] = qx; mb[0] = qz;
            ma[1] = qy; mb[1] = qz;
            ma[2] = qw; mb[2] = qx;
            ma[3] = qw; mb[3] = qy;
          end
          5'd2: begin
            ma[0] = qw; mb[0] = qz;
          end
          default: begin
          end
        endcase
      end
      jhsm_pkg::ST_SCALE: begin
        mb[0] = scl[0];
        mb[1] = scl[1];
        mb[2] = scl[2];
        case (cnt)
          5'd0: begin
            ma[0] = rot[0]; ma[1] = rot[1]; ma[2] = rot[2];
          end
          5'd1: begin
            ma[0] = rot[3]; ma[1] = rot[4]; ma[2] = rot[5];
          end
          5'd2: begin
            ma[0] = rot[6]; ma[1] = rot[7]; ma[2] = rot[8];
          end
          default: begin
          end
        endcase
      end
      jhsm_pkg::ST_WORLD: begin
        if (cnt < 5'd16) begin
          iss_w = 1'b1;
          for (int k = 0; k < 4; k++) begin
            if (has_par) begin
              ma[k] = world_rdata[k];
            end else begin
              ma[k] = (2'(k) == cnt[3:2]) ? ONE : 32'sd0;
            end
            if (k < 3) begin
              mb[k] = loc[k][cnt[1:0]];
            end else begin
              mb[k] = (cnt[1:0] == 2'd3) ? ONE : 32'sd0;
            end
          end
        end
      end
      jhsm_pkg::ST_SKIN: begin
        if (cnt < 5'd16) begin
          iss_s = 1'b1;
          for (int k = 0; k < 4; k++) begin
            ma[k] = world_m[cnt[3:2]][k];
            mb[k] = bind_m[k][cnt[1:0]];
          end
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= jhsm_pkg::ST_IDLE;
      cnt    <= '0;
      pend_w <= 1'b0;
      pend_s <= 1'b0;
    end else begin
      state  <= state_next;
      cnt    <= cnt_next;
      pend_w <= iss_w;
      pend_s <= iss_s;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    pidx <= cnt[3:0];
    if (start) begin
      joint_q   <= pose.joint;
      loc[0][3] <= pose.word0;
      loc[1][3] <= pose.word1;
      loc[2][3] <= pose.word2;
      qx        <= pose.word3;
      qy        <= pose.word4;
      qz        <= pose.word5;
      qw        <= pose.word6;
      scl[0]    <= pose.word7;
      scl[1]    <= pose.word8;
      scl[2]    <= pose.word9;
    end
    if (state == jhsm_pkg::ST_QUAT) begin
      if (cnt == 5'd0) begin
        par_q <= par_rdata;
      end else begin
        bind_m[2'(cnt - 5'd1)] <= bind_rdata;
      end
      if (cnt == 5'd1) begin
        qp[0] <= $signed(pr[0]);
        qp[1] <= $signed(pr[1]);
        qp[2] <= $signed(pr[2]);
        qp[3] <= $signed(pr[3]);
      end
      if (cnt == 5'd2) begin
        qp[4] <= $signed(pr[0]);
        qp[5] <= $signed(pr[1]);
        qp[6] <= $signed(pr[2]);
        qp[7] <= $signed(pr[3]);
      end
      if (cnt == 5'd3) begin
        qp[8] <= $signed(pr[0]);
      end
      if (cnt == 5'd4) begin
        for (int i = 0; i < 9; i++) begin
          rot[i] <= rot_n[i];
        end
      end
    end
    // local = rotate * scale, one row per cycle
    if (state == jhsm_pkg::ST_SCALE && cnt != 5'd0) begin
      for (int c = 0; c < 3; c++) begin
        loc[2'(cnt - 5'd1)][c] <= jhsm_pkg::sat32(SW'($signed(pr[c])));
      end
    end
    if (pend_w) begin
      world_m[pidx[3:2]][pidx[1:0]] <= sum_sat;
    end
    if (pend_s) begin
      skin_m[pidx[3:2]][pidx[1:0]] <= sum_sat;
    end
  end

  `JHSM_ASSERT_IMP(a_no_overlap, pose.ready, !palette.valid, "input open while rows pending")
  `JHSM_ASSERT_NXT(a_done_idle, palette.valid && palette.ready && palette.last_row, pose.ready, "not idle after last row")
  `JHSM_ASSERT_NXT(a_row_step, palette.valid && palette.ready && !palette.last_row, palette.valid && palette.out_row == $past(palette.out_row) + 2'd1, "row order broken")
  `JHSM_ASSERT_NXT(a_joint_hold, palette.valid && palette.ready && !palette.last_row, palette.out_joint == $past(palette.out_joint), "joint changed mid matrix")

endmodule

@@ verif/tb.sv @@
// Testbench for the skinning matrix palette: self-checking with a scoreboard.
`timescale 1ns / 1ps
module tb;

  localparam int NJ = 64;
  localparam int FB = 16;
  localparam int RANDOM_ITEMS = 165;

  typedef struct {
    logic [5:0]         joint;
    logic [1:0]         row;
    logic signed [31:0] e [4];
    logic               last;
  } skin_row_t;

  typedef logic signed [31:0] mat_t [16];

  // Scoreboard: mirrors the block's stores and predicts skinning rows
  class skin_scoreboard;
    logic signed [31:0] bind_m [NJ][16];
    logic [5:0]         parent [NJ];
    logic signed [31:0] world_m [NJ][16];
    skin_row_t          pending [$];
    int                 mismatches;

    function longint fxmul(longint a, longint b);
      return (a * b) >>> FB;
    endfunction

    function logic signed [31:0] clamp(longint v);
      if (v > 64'sd2147483647) return 32'sh7fff_ffff;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
    endfunction

    function mat_t mat_mul(mat_t a, mat_t b);
      mat_t c;
      longint acc;
      for (int r = 0; r < 4; r++)
        for (int col = 0; col < 4; col++) begin
          acc = 0;
          for (int k = 0; k < 4; k++) acc += fxmul(a[r*4+k], b[k*4+col]);
          c[r*4+col] = clamp(acc);
        end
      return c;
    endfunction

    // Note one accepted request
    function void note_request(logic mode, logic [5:0] j, logic signed [31:0] w [10]);
      longint one, xx, yy, zz, xy, xz, yz, wx, wy, wz;
      logic signed [31:0] rot [9];
      mat_t loc, pw, wm, bm, sk;
      skin_row_t sr;
      longint par;
      if (mode == jhsm_pkg::MODE_LOAD) begin
        if (w[0] < 0 || w[0] > 3) return;
        for (int i = 0; i < 4; i++) bind_m[j][w[0]*4+i] = w[1+i];
        par = w[5];
        if (par < 0 || par >= j) par = j;
        parent[j] = par[5:0];
        return;
      end
      one = longint'(1) << FB;
      xx = fxmul(w[3], w[3]); yy = fxmul(w[4], w[4]); zz = fxmul(w[5], w[5]);
      xy = fxmul(w[3], w[4]); xz = fxmul(w[3], w[5]); yz = fxmul(w[4], w[5]);
      wx = fxmul(w[6], w[3]); wy = fxmul(w[6], w[4]); wz = fxmul(w[6], w[5]);
      rot[0] = clamp(one - 2*(yy+zz)); rot[1] = clamp(2*(xy-wz));
      rot[2] = clamp(2*(xz+wy));       rot[3] = clamp(2*(xy+wz));
      rot[4] = clamp(one - 2*(xx+zz)); rot[5] = clamp(2*(yz-wx));
      rot[6] = clamp(2*(xz-wy));       rot[7] = clamp(2*(yz+wx));
      rot[8] = clamp(one - 2*(xx+yy));
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) loc[r*4+c] = clamp(fxmul(rot[r*3+c], w[7+c]));
        loc[r*4+3] = w[r];
      end
      loc[12] = 0; loc[13] = 0; loc[14] = 0; loc[15] = one;
      for (int i = 0; i < 16; i++) pw[i] = (i % 5 == 0) ? one : 0;
      if (parent[j] < j)
        for (int i = 0; i < 16; i++) pw[i] = world_m[parent[j]][i];
      wm = mat_mul(pw, loc);
      for (int i = 0; i < 16; i++) begin
        world_m[j][i] = wm[i];
        bm[i] = bind_m[j][i];
      end
      sk = mat_mul(wm, bm);
      for (int r = 0; r < 4; r++) begin
        sr.joint = j; sr.row = r; sr.last = (r == 3);
        for (int c = 0; c < 4; c++) sr.e[c] = sk[r*4+c];
        pending = {pending, sr};
      end
    endfunction

    // Check one accepted result row
    function void check_row(skin_row_t got);
      skin_row_t exp_r;
      bit bad;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected row joint %0d row %0d", got.joint, got.row);
        return;
      end
      exp_r = pending.pop_front();
      bad = (got.joint !== exp_r.joint) || (got.row !== exp_r.row) ||
            (got.last !== exp_r.last);
      for (int c = 0; c < 4; c++) if (got.e[c] !== exp_r.e[c]) bad = 1;
      if (bad) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp j%0d r%0d %h %h %h %h l%0d got j%0d r%0d %h %h %h %h l%0d",
                   exp_r.joint, exp_r.row, exp_r.e[0], exp_r.e[1], exp_r.e[2], exp_r.e[3],
                   exp_r.last, got.joint, got.row, got.e[0], got.e[1], got.e[2],
                   got.e[3], got.last);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  jhsm_pose_if pose ();
  jhsm_row_if palette ();
  skin_scoreboard sb;
  int rx_cycle = 0;

  joint_hierarchy_skinning_matrices DUT (.clk(clk), .rst(rst), .pose(pose), .palette(palette));

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Receiver: stall pattern of its own, with stall-free stretches
  initial begin
    palette.ready = 0;
    forever begin
      @(posedge clk);
      rx_cycle++;
      if ((rx_cycle / 256) % 3 == 0) palette.ready <= 1;
      else palette.ready <= ((rx_cycle % 7) < 4) || ($urandom_range(0, 3) == 0);
    end
  end

  // Collect results
  always @(posedge clk) begin
    skin_row_t got;
    if (!rst && palette.valid && palette.ready) begin
      got.joint = palette.out_joint; got.row = palette.out_row; got.last = palette.last_row;
      got.e[0] = palette.elem0; got.e[1] = palette.elem1;
      got.e[2] = palette.elem2; got.e[3] = palette.elem3;
      sb.check_row(got);
    end
  end

  int burst_left = 0;

  // Send one request, with burst/gap idling
  task automatic send(logic mode, logic [5:0] j, logic signed [31:0] w [10]);
    if (burst_left == 0) begin
      pose.valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 8);
    end
    burst_left--;
    pose.valid <= 1; pose.mode <= mode; pose.joint <= j;
    pose.word0 <= w[0]; pose.word1 <= w[1]; pose.word2 <= w[2]; pose.word3 <= w[3];
    pose.word4 <= w[4]; pose.word5 <= w[5]; pose.word6 <= w[6]; pose.word7 <= w[7];
    pose.word8 <= w[8]; pose.word9 <= w[9];
    do @(posedge clk); while (!pose.ready);
    sb.note_request(mode, j, w);
  endtask

  function automatic logic signed [31:0] rnd_word();
    case ($urandom_range(0, 5))
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2: return $signed($urandom_range(0, 131072)) - 65536;
      default: return $urandom;
    endcase
  endfunction

  task automatic load_bind(logic [5:0] j, int par, bit wild);
    logic signed [31:0] w [10];
    for (int r = 0; r < 4; r++) begin
      w[0] = r;
      for (int c = 0; c < 4; c++)
        w[1+c] = wild ? rnd_word() : ((r == c) ? 32'sh10000 : 0)
                 + $signed($urandom_range(0, 8192)) - 4096;
      w[5] = par;
      for (int i = 6; i < 10; i++) w[i] = $urandom;
      send(jhsm_pkg::MODE_LOAD, j, w);
    end
  endtask

  task automatic pose_joint(logic [5:0] j, bit wild);
    logic signed [31:0] w [10];
    for (int i = 0; i < 10; i++) w[i] = wild ? rnd_word() :
        $signed($urandom_range(0, 262144)) - 131072;
    if (!wild) for (int i = 3; i < 7; i++) w[i] = $signed($urandom_range(0, 65536)) - 32768;
    send(jhsm_pkg::MODE_POSE, j, w);
  endtask

  initial begin
    logic signed [31:0] w [10];
    int nj, sent;
    sb = new();
    pose.valid = 0; pose.mode = 0; pose.joint = 0;
    pose.word0 = 0; pose.word1 = 0; pose.word2 = 0; pose.word3 = 0; pose.word4 = 0;
    pose.word5 = 0; pose.word6 = 0; pose.word7 = 0; pose.word8 = 0; pose.word9 = 0;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: root, bad parents, extremes, ignored rows
    load_bind(0, -1, 0);
    load_bind(1, 0, 1);
    load_bind(2, 63, 0);
    load_bind(63, 1, 0);
    for (int i = 0; i < 10; i++) w[i] = 0;
    w[0] = 4; send(jhsm_pkg::MODE_LOAD, 1, w);          // row out of range
    w[0] = -1; send(jhsm_pkg::MODE_LOAD, 1, w);
    w[6] = 32'sh10000; w[7] = 32'sh10000; w[8] = 32'sh10000; w[9] = 32'sh10000;
    send(jhsm_pkg::MODE_POSE, 0, w);                   // identity pose
    for (int i = 0; i < 10; i++) w[i] = 32'sh7fff_ffff;
    send(jhsm_pkg::MODE_POSE, 1, w);
    for (int i = 0; i < 10; i++) w[i] = 32'sh8000_0000;
    send(jhsm_pkg::MODE_POSE, 2, w);
    pose_joint(63, 1);
    pose_joint(0, 0);                        // new parent world for joint 1 next
    pose_joint(1, 0);

    // Random: build skeletons then animate frames in joint order
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      nj = $urandom_range(2, 12);
      for (int j = 0; j < nj; j++) begin
        load_bind(j, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 70) - 3
                     : (j == 0 ? j : $urandom_range(0, j - 1)), $urandom_range(0, 4) == 0);
        sent += 4;
      end
      repeat ($urandom_range(1, 3)) begin
        for (int j = 0; j < nj; j++) begin
          pose_joint(j, $urandom_range(0, 5) == 0);
          sent++;
        end
      end
    end
    pose.valid <= 0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule
